// ===== rtl/rme_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix to Euler angles: shared package
// Widths, angle constants, beat structs and the CORDIC start/finish helpers.
// ----------------------------------------------------------------------------
package rme_pkg;

  localparam int FRAC_BITS_DEF     = 16;
  localparam int CORDIC_STAGES_DEF = 18;

  localparam int IN_W       = 18;
  localparam int OP_W       = 20;
  localparam int SQ_W       = 36;
  localparam int ROOT_W     = 18;
  localparam int REM_W      = 21;
  localparam int XY_W       = 48;
  localparam int Z_W        = 36;
  localparam int GUARD      = 24;
  localparam int THR_W      = 17;
  localparam int ANGLE_XZ_W = 19;
  localparam int ANGLE_Y_W  = 18;
  localparam int Q_FRAC     = 30;

  localparam logic signed [Z_W-1:0] PI_Q30  = 36'sd3373259426;
  localparam logic signed [Z_W-1:0] HPI_Q30 = 36'sd1686629713;

  typedef struct packed {
    logic signed [OP_W-1:0] xx;
    logic signed [OP_W-1:0] yx;
    logic signed [OP_W-1:0] yy;
    logic signed [OP_W-1:0] yz;
    logic signed [OP_W-1:0] zx;
    logic signed [OP_W-1:0] zy;
    logic signed [OP_W-1:0] zz;
  } op_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [SQ_W-1:0]   rad;
  } sqrt_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   zero_y;
    logic                   xneg;
  } cordic_t;

  function automatic logic signed [Z_W-1:0] atan_q30(input int i);
    logic signed [Z_W-1:0] r;
    unique case (i)
      0:  r = 36'sd843314857;
      1:  r = 36'sd497837829;
      2:  r = 36'sd263043837;
      3:  r = 36'sd133525159;
      4:  r = 36'sd67021687;
      5:  r = 36'sd33543516;
      6:  r = 36'sd16775851;
      7:  r = 36'sd8388437;
      8:  r = 36'sd4194283;
      9:  r = 36'sd2097149;
      10: r = 36'sd1048576;
      11: r = 36'sd524288;
      12: r = 36'sd262144;
      13: r = 36'sd131072;
      14: r = 36'sd65536;
      15: r = 36'sd32768;
      16: r = 36'sd16384;
      17: r = 36'sd8192;
      18: r = 36'sd4096;
      19: r = 36'sd2048;
      20: r = 36'sd1024;
      21: r = 36'sd512;
      22: r = 36'sd256;
      23: r = 36'sd128;
      24: r = 36'sd64;
      25: r = 36'sd32;
      26: r = 36'sd16;
      27: r = 36'sd8;
      28: r = 36'sd4;
      29: r = 36'sd2;
      30: r = 36'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [Z_W-1:0] to_frac(input logic signed [Z_W-1:0] z,
                                                    input int frac);
    int s;
    logic signed [Z_W-1:0] half;
    s = Q_FRAC - frac;
    half = '0;
    if (s == 0) begin
      return z;
    end
    half[s-1] = 1'b1;
    return (z + half) >>> s;
  endfunction

  function automatic cordic_t cordic_init(input logic signed [OP_W-1:0] y,
                                          input logic signed [OP_W-1:0] x);
    cordic_t c;
    logic signed [OP_W-1:0] xa;
    logic signed [OP_W-1:0] ya;
    c.zero_y = (y == '0);
    c.xneg   = x[OP_W-1];
    c.z      = '0;
    xa = x;
    ya = y;
    if (c.xneg) begin
      c.z = (y > 0) ? PI_Q30 : -PI_Q30;
      xa  = -x;
      ya  = -y;
    end
    c.x = XY_W'(xa) <<< GUARD;
    c.y = XY_W'(ya) <<< GUARD;
    return c;
  endfunction

  function automatic logic signed [Z_W-1:0] cordic_finish(input cordic_t c,
                                                          input logic signed [Z_W-1:0] lim_pi,
                                                          input logic signed [Z_W-1:0] lim,
                                                          input int frac);
    logic signed [Z_W-1:0] r;
    if (c.zero_y) begin
      r = c.xneg ? lim_pi : '0;
    end else begin
      r = to_frac(c.z, frac);
    end
    if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

endpackage

// ===== rtl/rme_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Square root cell
// Resolves one root bit per cycle from the next two radicand bits.
// ----------------------------------------------------------------------------
module rme_sqrt_cell (
  input  logic            clk,
  input  rme_pkg::sqrt_t  d,
  output rme_pkg::sqrt_t  q
);

  logic [rme_pkg::REM_W-1:0] r2;
  logic [rme_pkg::REM_W-1:0] trial;
  rme_pkg::sqrt_t            q_next;

  always_comb begin
    r2    = {d.rem[rme_pkg::REM_W-3:0], d.rad[rme_pkg::SQ_W-1 -: 2]};
    trial = {1'b0, d.root, 2'b01};
    q_next.rad = d.rad << 2;
    if (r2 >= trial) begin
      q_next.rem  = r2 - trial;
      q_next.root = {d.root[rme_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      q_next.rem  = r2;
      q_next.root = {d.root[rme_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

// ===== rtl/rme_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// CORDIC vectoring cell
// One micro-rotation toward y = 0 with the angle step of its own stage.
// ----------------------------------------------------------------------------
module rme_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic             clk,
  input  rme_pkg::cordic_t d,
  output rme_pkg::cordic_t q
);

  logic signed [rme_pkg::XY_W-1:0] xs;
  logic signed [rme_pkg::XY_W-1:0] ys;
  rme_pkg::cordic_t                q_next;

  always_comb begin
    xs = d.x >>> STAGE;
    ys = d.y >>> STAGE;
    q_next = d;
    if (d.y > 0) begin
      q_next.x = d.x + ys;
      q_next.y = d.y - xs;
      q_next.z = d.z + rme_pkg::atan_q30(STAGE);
    end else begin
      q_next.x = d.x - ys;
      q_next.y = d.y + xs;
      q_next.z = d.z - rme_pkg::atan_q30(STAGE);
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

// ===== rtl/rotation_matrix_to_euler_angles.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix to Euler angles (X-Y-Z)
// Throughput: one matrix per cycle; busy stays low and the receiver cannot stall.
// The square root row (18 cells) and the CORDIC rows set the latency.
// Reset clears the pipeline valid bits, done and the gimbal threshold.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_angles #(
  parameter int FRAC_BITS     = rme_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = rme_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [rme_pkg::IN_W-1:0]         m_xx,
  input  logic signed [rme_pkg::IN_W-1:0]         m_xz,
  input  logic signed [rme_pkg::IN_W-1:0]         m_yx,
  input  logic signed [rme_pkg::IN_W-1:0]         m_yy,
  input  logic signed [rme_pkg::IN_W-1:0]         m_yz,
  input  logic signed [rme_pkg::IN_W-1:0]         m_zx,
  input  logic signed [rme_pkg::IN_W-1:0]         m_zy,
  input  logic signed [rme_pkg::IN_W-1:0]         m_zz,
  input  logic                                    reflected,
  input  logic                                    threshold_we,
  input  logic [rme_pkg::THR_W-1:0]               threshold_wdata,
  output logic                                    done,
  output logic signed [rme_pkg::ANGLE_XZ_W-1:0]   angle_x,
  output logic signed [rme_pkg::ANGLE_Y_W-1:0]    angle_y,
  output logic signed [rme_pkg::ANGLE_XZ_W-1:0]   angle_z
);

  localparam int ROOT_W = rme_pkg::ROOT_W;
  localparam int OPD    = ROOT_W + 3;
  localparam int N      = CORDIC_STAGES;
  localparam logic signed [rme_pkg::Z_W-1:0] LIM_PI  =
    rme_pkg::to_frac(rme_pkg::PI_Q30, FRAC_BITS);
  localparam logic signed [rme_pkg::Z_W-1:0] LIM_HPI =
    rme_pkg::to_frac(rme_pkg::HPI_Q30, FRAC_BITS);

  logic [rme_pkg::THR_W-1:0] threshold;
  rme_pkg::op_t              op_in;
  rme_pkg::op_t              op_d [0:OPD-1];
  logic [OPD-1:0]            vld;
  logic [rme_pkg::SQ_W-1:0]  xx2;
  logic [rme_pkg::SQ_W-1:0]  yx2;
  rme_pkg::sqrt_t            sq_s [0:ROOT_W];
  rme_pkg::cordic_t          cx [0:N];
  rme_pkg::cordic_t          cy [0:N];
  rme_pkg::cordic_t          cz [0:N];
  logic [N:0]                vld_c;
  logic [N:0]                gim;
  rme_pkg::op_t              op_s;
  logic [ROOT_W-1:0]         cosb;
  logic                      lock;
  logic signed [rme_pkg::OP_W-1:0] cosb_op;
  logic signed [rme_pkg::Z_W-1:0]  ax;
  logic signed [rme_pkg::Z_W-1:0]  ay;
  logic signed [rme_pkg::Z_W-1:0]  az;

  assign busy = 1'b0;

  always_comb begin
    op_in.xx = rme_pkg::OP_W'(m_xx);
    op_in.yx = rme_pkg::OP_W'(m_yx);
    op_in.yy = rme_pkg::OP_W'(m_yy);
    op_in.zx = rme_pkg::OP_W'(m_zx);
    op_in.zy = rme_pkg::OP_W'(m_zy);
    op_in.yz = reflected ? -rme_pkg::OP_W'(m_yz) : rme_pkg::OP_W'(m_yz);
    op_in.zz = reflected ? -rme_pkg::OP_W'(m_zz) : rme_pkg::OP_W'(m_zz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
      vld       <= '0;
      vld_c     <= '0;
      done      <= 1'b0;
    end else begin
      if (threshold_we) begin
        threshold <= threshold_wdata;
      end
      vld   <= {vld[OPD-2:0], start};
      vld_c <= {vld_c[N-1:0], vld[OPD-1]};
      done  <= vld_c[N];
    end
  end

  always_ff @(posedge clk) begin
    op_d[0] <= op_in;
    for (int k = 1; k < OPD; k++) begin
      op_d[k] <= op_d[k-1];
    end
    xx2 <= rme_pkg::SQ_W'(op_d[0].xx * op_d[0].xx);
    yx2 <= rme_pkg::SQ_W'(op_d[0].yx * op_d[0].yx);
    sq_s[0].rem  <= '0;
    sq_s[0].root <= '0;
    sq_s[0].rad  <= xx2 + yx2;
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    rme_sqrt_cell u_cell (
      .clk (clk),
      .d   (sq_s[k]),
      .q   (sq_s[k+1])
    );
  end

  always_comb begin
    op_s    = op_d[OPD-1];
    cosb    = sq_s[ROOT_W].root;
    cosb_op = rme_pkg::OP_W'({1'b0, cosb});
    lock    = !(cosb > ROOT_W'(threshold));
  end

  always_ff @(posedge clk) begin
    cx[0]  <= lock ? rme_pkg::cordic_init(-op_s.yz, op_s.yy)
                   : rme_pkg::cordic_init(op_s.zy, op_s.zz);
    cy[0]  <= rme_pkg::cordic_init(-op_s.zx, cosb_op);
    cz[0]  <= rme_pkg::cordic_init(op_s.yx, op_s.xx);
    gim[0] <= lock;
    for (int k = 1; k <= N; k++) begin
      gim[k] <= gim[k-1];
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_cordic
    rme_cordic_cell #(.STAGE(k)) u_cx (.clk(clk), .d(cx[k]), .q(cx[k+1]));
    rme_cordic_cell #(.STAGE(k)) u_cy (.clk(clk), .d(cy[k]), .q(cy[k+1]));
    rme_cordic_cell #(.STAGE(k)) u_cz (.clk(clk), .d(cz[k]), .q(cz[k+1]));
  end

  always_comb begin
    ax = rme_pkg::cordic_finish(cx[N], LIM_PI, LIM_PI, FRAC_BITS);
    ay = rme_pkg::cordic_finish(cy[N], LIM_PI, LIM_HPI, FRAC_BITS);
    az = gim[N] ? '0 : rme_pkg::cordic_finish(cz[N], LIM_PI, LIM_PI, FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    angle_x <= rme_pkg::ANGLE_XZ_W'(ax);
    angle_y <= rme_pkg::ANGLE_Y_W'(ay);
    angle_z <= rme_pkg::ANGLE_XZ_W'(az);
  end

endmodule

// ===== rtl/rme_checker.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix to Euler angles: port checker
// Latency, reset and angle range checks, bound to the top level.
// ----------------------------------------------------------------------------
module rme_checker #(
  parameter int FRAC_BITS     = rme_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = rme_pkg::CORDIC_STAGES_DEF
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  start,
  input logic                                  busy,
  input logic                                  done,
  input logic signed [rme_pkg::ANGLE_XZ_W-1:0] angle_x,
  input logic signed [rme_pkg::ANGLE_Y_W-1:0]  angle_y
);

  localparam int LAT = rme_pkg::ROOT_W + CORDIC_STAGES + 5;
  localparam logic signed [rme_pkg::Z_W-1:0] LIM_PI  =
    rme_pkg::to_frac(rme_pkg::PI_Q30, FRAC_BITS);
  localparam logic signed [rme_pkg::Z_W-1:0] LIM_HPI =
    rme_pkg::to_frac(rme_pkg::HPI_Q30, FRAC_BITS);

  a_reset_clears: assert property (@(posedge clk) rst |=> !done)
    else $error("done after reset");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("beat not delivered on time");

  a_range_y: assert property (@(posedge clk) disable iff (rst || FRAC_BITS != 16)
    done |-> (rme_pkg::Z_W'(angle_y) <= LIM_HPI && rme_pkg::Z_W'(angle_y) >= -LIM_HPI))
    else $error("angle_y out of range");

  a_range_x: assert property (@(posedge clk) disable iff (rst || FRAC_BITS != 16)
    done |-> (rme_pkg::Z_W'(angle_x) <= LIM_PI && rme_pkg::Z_W'(angle_x) >= -LIM_PI))
    else $error("angle_x out of range");

endmodule

bind rotation_matrix_to_euler_angles rme_checker #(
  .FRAC_BITS     (FRAC_BITS),
  .CORDIC_STAGES (CORDIC_STAGES)
) u_rme_checker (.*);
